// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the descriptor ring
// each macro takes a label, a clock, an active-low reset, an antecedent,
// a consequent and a message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/fdr_pkg.sv =====
package fdr_pkg;

    // operation codes
    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_POP      = 2'd1;
    localparam logic [1:0] OP_RELEASE  = 2'd2;
    localparam logic [1:0] OP_SHUTDOWN = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_LEN     = 3'd1;
    localparam logic [2:0] ST_SHUT        = 3'd2;
    localparam logic [2:0] ST_NEW_DROPPED = 3'd3;
    localparam logic [2:0] ST_EMPTY       = 3'd4;
    localparam logic [2:0] ST_DONE        = 3'd5;

    // one stored frame descriptor
    typedef struct packed {
        logic [63:0] seq;
        logic [63:0] stamp;
        logic [31:0] format;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] length;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    // decision made when a word is accepted, waiting for the descriptor read
    typedef struct packed {
        logic [2:0] status;
        logic       oldest;
        logic [3:0] slot;
        logic       pop_ok;
    } res_t;

    // running totals
    typedef struct packed {
        logic [31:0] pushed;
        logic [31:0] dropped;
        logic [31:0] popped;
    } cnt_t;

endpackage

// ===== hw/rtl/fdr_cmd_if.sv =====
interface fdr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [63:0] frame_seq;
    logic [63:0] frame_time;
    logic [31:0] pix_format;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [31:0] frame_length;
    logic [3:0]  release_slot;

    modport source (
        output valid, op, frame_seq, frame_time, pix_format, frame_width,
               frame_height, frame_length, release_slot,
        input  ready
    );

    modport sink (
        input  valid, op, frame_seq, frame_time, pix_format, frame_width,
               frame_height, frame_length, release_slot,
        output ready
    );
endinterface

// ===== hw/rtl/fdr_rsp_if.sv =====
interface fdr_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        oldest_dropped;
    logic [3:0]  slot_index;
    logic [63:0] out_seq;
    logic [63:0] out_time;
    logic [31:0] out_format;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [31:0] out_length;
    logic [31:0] pushed_total;
    logic [31:0] dropped_total;
    logic [31:0] popped_total;

    modport source (
        output valid, status, oldest_dropped, slot_index, out_seq, out_time,
               out_format, out_width, out_height, out_length, pushed_total,
               dropped_total, popped_total,
        input  ready
    );

    modport sink (
        input  valid, status, oldest_dropped, slot_index, out_seq, out_time,
               out_format, out_width, out_height, out_length, pushed_total,
               dropped_total, popped_total,
        output ready
    );
endinterface

// ===== hw/rtl/fdr_ram.sv =====
module fdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/fdr_ctrl.sv =====
module fdr_ctrl
    import fdr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_data,
    fdr_cmd_if.sink                  cmd,
    input  logic                     s1_take,
    output logic                     s1_valid,
    output res_t                     s1_res,
    output cnt_t                     cnt,
    output logic                     ram_we,
    output logic [$clog2(DEPTH)-1:0] ram_waddr,
    output desc_t                    ram_wdata,
    output logic                     ram_re,
    output logic [$clog2(DEPTH)-1:0] ram_raddr
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]      max_len_reg;
    logic [PW-1:0]    wp_reg, wp_next;
    logic [PW-1:0]    rp_reg, rp_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [DEPTH-1:0] held_reg, held_next;
    logic             stopped_reg, stopped_next;
    cnt_t             cnt_reg, cnt_next;
    logic             s1_valid_reg;
    res_t             s1_res_reg, res_d;

    logic       accept;
    logic       full;
    logic       tail_held;
    logic       head_held;
    logic       bad_len;
    logic       wr;
    logic [1:0] drop_inc;

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        next_pos = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign cmd.ready = !s1_valid_reg || s1_take;
    assign accept    = cmd.valid && cmd.ready;

    assign full      = (fill_reg == CW'(DEPTH));
    assign tail_held = held_reg[rp_reg];
    assign head_held = held_reg[wp_reg];
    assign bad_len   = (cmd.frame_length == 32'd0) || (cmd.frame_length > max_len_reg);

    // decide the operation against the current ring state
    always_comb
    begin
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        wr           = 1'b0;
        drop_inc     = 2'd0;
        res_d.status = ST_DONE;
        res_d.oldest = 1'b0;
        res_d.slot   = 4'd0;
        res_d.pop_ok = 1'b0;

        unique case (cmd.op)
            OP_PUSH:
            begin
                if (bad_len)
                begin
                    res_d.status = ST_BAD_LEN;
                end
                else if (stopped_reg)
                begin
                    res_d.status = ST_SHUT;
                end
                else if (full && tail_held)
                begin
                    res_d.status = ST_NEW_DROPPED;
                    drop_inc     = 2'd1;
                end
                else
                begin
                    if (full)
                    begin
                        res_d.oldest = 1'b1;
                        rp_next      = next_pos(rp_reg);
                    end
                    if (head_held)
                    begin
                        res_d.status = ST_NEW_DROPPED;
                        drop_inc     = {1'b0, full} + 2'd1;
                    end
                    else
                    begin
                        res_d.status = ST_OK;
                        res_d.slot   = 4'(wp_reg);
                        drop_inc     = {1'b0, full};
                        wr           = 1'b1;
                        wp_next      = next_pos(wp_reg);
                    end
                end
            end
            OP_POP:
            begin
                if (stopped_reg)
                begin
                    res_d.status = ST_SHUT;
                end
                else if (fill_reg == '0)
                begin
                    res_d.status = ST_EMPTY;
                end
                else
                begin
                    res_d.status     = ST_OK;
                    res_d.slot       = 4'(rp_reg);
                    res_d.pop_ok     = 1'b1;
                    held_next[rp_reg] = 1'b1;
                    rp_next          = next_pos(rp_reg);
                end
            end
            OP_RELEASE:
            begin
                // slots beyond the ring never match
                for (int i = 0; i < DEPTH; i++)
                begin
                    if ({28'd0, cmd.release_slot} == 32'(i))
                    begin
                        held_next[i] = 1'b0;
                    end
                end
            end
            OP_SHUTDOWN:
            begin
                stopped_next = 1'b1;
            end
            default:
            begin
                res_d.status = ST_DONE;
            end
        endcase

        fill_next = fill_reg - CW'(res_d.oldest) - CW'(res_d.pop_ok) + CW'(wr);

        cnt_next.pushed  = cnt_reg.pushed + 32'(wr);
        cnt_next.dropped = cnt_reg.dropped + 32'(drop_inc);
        cnt_next.popped  = cnt_reg.popped + 32'(res_d.pop_ok);
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_data;
        end
    end

    // ring state, applied on an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            rp_reg      <= '0;
            fill_reg    <= '0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else if (accept)
        begin
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            fill_reg    <= fill_next;
            held_reg    <= held_next;
            stopped_reg <= stopped_next;
            cnt_reg     <= cnt_next;
        end
    end

    // decision waits here for the descriptor read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= res_d;
        end
    end

    // descriptor memory access
    assign ram_we           = accept && wr;
    assign ram_waddr        = wp_reg;
    assign ram_wdata.seq    = cmd.frame_seq;
    assign ram_wdata.stamp  = cmd.frame_time;
    assign ram_wdata.format = cmd.pix_format;
    assign ram_wdata.width  = cmd.frame_width;
    assign ram_wdata.height = cmd.frame_height;
    assign ram_wdata.length = cmd.frame_length;
    assign ram_re           = accept && res_d.pop_ok;
    assign ram_raddr        = rp_reg;

    assign s1_valid = s1_valid_reg;
    assign s1_res   = s1_res_reg;
    assign cnt      = cnt_reg;

endmodule

// ===== hw/rtl/frame_descriptor_ring_drop_oldest.sv =====
// channel | dir | handshake      | carries
// cmd     | in  | valid / ready  | op, descriptor fields, release slot
// rsp     | out | valid / ready  | status, slot, popped descriptor, totals
// cfg     | in  | cfg_we         | max_frame_length
//
// one word per cycle sustained while rsp is ready; a taken word's decision
// is registered with the descriptor ram read, then in the output register
// the ring pointers, held flags and totals update in the accept cycle
// reset clears pointers, held flags, shutdown and totals; no clearing pass
// a stalled rsp holds the output register, then the decision stage, then cmd
`include "assert_macros.svh"

module frame_descriptor_ring_drop_oldest
    import fdr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    fdr_cmd_if.sink     cmd,
    fdr_rsp_if.source   rsp
);

    localparam int PW = $clog2(DEPTH);

    logic          s1_valid;
    logic          s1_take;
    res_t          s1_res;
    cnt_t          cnt;
    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    desc_t         ram_wdata;
    logic          ram_re;
    logic [PW-1:0] ram_raddr;
    logic [DESC_W-1:0] ram_rdata;
    desc_t         rd_desc;

    logic  out_valid_reg;
    res_t  out_res_reg;
    desc_t out_desc_reg;
    cnt_t  out_cnt_reg;

    fdr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .s1_take   (s1_take),
        .s1_valid  (s1_valid),
        .s1_res    (s1_res),
        .cnt       (cnt),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    fdr_ram #(
        .WIDTH (DESC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_desc = desc_t'(ram_rdata);
    assign s1_take = s1_valid && (!out_valid_reg || rsp.ready);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // totals are still those of this word while it waits in the decision stage
    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            out_res_reg  <= s1_res;
            out_cnt_reg  <= cnt;
            out_desc_reg <= s1_res.pop_ok ? rd_desc : '0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_res_reg.status;
    assign rsp.oldest_dropped = out_res_reg.oldest;
    assign rsp.slot_index     = out_res_reg.slot;
    assign rsp.out_seq        = out_desc_reg.seq;
    assign rsp.out_time       = out_desc_reg.stamp;
    assign rsp.out_format     = out_desc_reg.format;
    assign rsp.out_width      = out_desc_reg.width;
    assign rsp.out_height     = out_desc_reg.height;
    assign rsp.out_length     = out_desc_reg.length;
    assign rsp.pushed_total   = out_cnt_reg.pushed;
    assign rsp.dropped_total  = out_cnt_reg.dropped;
    assign rsp.popped_total   = out_cnt_reg.popped;

    // checks
    `ASSERT_NEXT(a_accept_fills_stage, clk, rst_n, cmd.valid && cmd.ready, s1_valid, "accepted word lost before decision stage")
    `ASSERT_NEXT(a_take_fills_out, clk, rst_n, s1_take, out_valid_reg, "decision moved but output register empty")
    `ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid && !s1_take, s1_valid, "waiting decision dropped")
    `ASSERT_SAME(a_oldest_status, clk, rst_n, s1_valid && s1_res.oldest, s1_res.status == ST_OK || s1_res.status == ST_NEW_DROPPED, "oldest drop with wrong status")

endmodule

// ===== bench/tb_frame_descriptor_ring_drop_oldest.sv =====
module tb_frame_descriptor_ring_drop_oldest
    import fdr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    // one command word as the bench sees it
    typedef struct packed {
        logic [1:0] op;
        desc_t      d;
        logic [3:0] rel;
    } ring_cmd_t;

    // one expected result word
    typedef struct packed {
        logic [2:0]  status;
        logic        oldest;
        logic [3:0]  slot;
        desc_t       d;
        logic [31:0] pushed;
        logic [31:0] dropped;
        logic [31:0] popped;
    } ring_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;

    fdr_cmd_if cmd_bus ();
    fdr_rsp_if rsp_bus ();

    frame_descriptor_ring_drop_oldest #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd_bus.sink),
        .rsp      (rsp_bus.source)
    );

    // shadow copy of the ring
    logic [31:0] max_len   = 32'hFFFF_FFFF;
    logic [3:0]  wr_pos    = '0;
    logic [3:0]  rd_pos    = '0;
    int          fill      = 0;
    logic [DEPTH-1:0] held = '0;
    logic        stopped   = 1'b0;
    desc_t       stash [DEPTH];
    logic [31:0] push_cnt  = '0;
    logic [31:0] drop_cnt  = '0;
    logic [31:0] pop_cnt   = '0;

    ring_rsp_t   outcome_q [$];
    int          fail_count = 0;

    // sender pacing
    int          burst_left = 0;
    bit          gaps_on    = 1'b1;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // outcome of one word on the shadow ring; positions wrap at 16 on their own
    function automatic ring_rsp_t ring_outcome(input ring_cmd_t c);
        ring_rsp_t r;
        r = '0;
        r.status = ST_DONE;
        case (c.op)
            OP_PUSH:
            begin
                if (c.d.length == 0 || c.d.length > max_len)
                begin
                    r.status = ST_BAD_LEN;
                end
                else if (stopped)
                begin
                    r.status = ST_SHUT;
                end
                else
                begin
                    r.status = ST_OK;
                    // full ring: discard the oldest or lose the new frame
                    if (fill >= DEPTH)
                    begin
                        if (held[rd_pos])
                        begin
                            r.status = ST_NEW_DROPPED;
                        end
                        else
                        begin
                            rd_pos   = rd_pos + 1'b1;
                            fill     = fill - 1;
                            r.oldest = 1'b1;
                        end
                        drop_cnt = drop_cnt + 1;
                    end
                    if (r.status == ST_OK && held[wr_pos])
                    begin
                        r.status = ST_NEW_DROPPED;
                        drop_cnt = drop_cnt + 1;
                    end
                    if (r.status == ST_OK)
                    begin
                        stash[wr_pos] = c.d;
                        r.slot   = wr_pos;
                        wr_pos   = wr_pos + 1'b1;
                        fill     = fill + 1;
                        push_cnt = push_cnt + 1;
                    end
                end
            end
            OP_POP:
            begin
                if (stopped)
                begin
                    r.status = ST_SHUT;
                end
                else if (fill == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.status     = ST_OK;
                    r.slot       = rd_pos;
                    r.d          = stash[rd_pos];
                    held[rd_pos] = 1'b1;
                    rd_pos       = rd_pos + 1'b1;
                    fill         = fill - 1;
                    pop_cnt      = pop_cnt + 1;
                end
            end
            OP_RELEASE:
            begin
                held[c.rel] = 1'b0;
            end
            default:
            begin
                stopped = 1'b1;
            end
        endcase
        r.pushed  = push_cnt;
        r.dropped = drop_cnt;
        r.popped  = pop_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin
        ring_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result word with no pending expectation");
                fail_count++;
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", want.status, rsp_bus.status);
                check_field("oldest_dropped", want.oldest, rsp_bus.oldest_dropped);
                check_field("slot_index", want.slot, rsp_bus.slot_index);
                check_field("out_seq", want.d.seq, rsp_bus.out_seq);
                check_field("out_time", want.d.stamp, rsp_bus.out_time);
                check_field("out_format", want.d.format, rsp_bus.out_format);
                check_field("out_width", want.d.width, rsp_bus.out_width);
                check_field("out_height", want.d.height, rsp_bus.out_height);
                check_field("out_length", want.d.length, rsp_bus.out_length);
                check_field("pushed_total", want.pushed, rsp_bus.pushed_total);
                check_field("dropped_total", want.dropped, rsp_bus.dropped_total);
                check_field("popped_total", want.popped, rsp_bus.popped_total);
            end
        end
    end

    // receiver stalls: steady, light random, or heavy random stretches
    initial
    begin
        int mode;
        rsp_bus.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(40, 200))
            begin
                @(posedge clk);
                case (mode)
                    0:       rsp_bus.ready <= 1'b1;
                    1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // send one word, predict at acceptance, then maybe idle
    task automatic send_word(input ring_cmd_t w);
        cmd_bus.valid        <= 1'b1;
        cmd_bus.op           <= w.op;
        cmd_bus.frame_seq    <= w.d.seq;
        cmd_bus.frame_time   <= w.d.stamp;
        cmd_bus.pix_format   <= w.d.format;
        cmd_bus.frame_width  <= w.d.width;
        cmd_bus.frame_height <= w.d.height;
        cmd_bus.frame_length <= w.d.length;
        cmd_bus.release_slot <= w.rel;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        outcome_q.push_back(ring_outcome(w));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                cmd_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // stop sending until every result is back
    task automatic drain();
        cmd_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (outcome_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [31:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        max_len = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random descriptor; length mostly legal for the current limit
    function automatic desc_t random_desc(input bit legal_only);
        desc_t d;
        int    sel;
        d.seq    = {$urandom, $urandom};
        d.stamp  = {$urandom, $urandom};
        d.format = $urandom;
        d.width  = 16'($urandom);
        d.height = 16'($urandom);
        sel = legal_only ? 19 : $urandom_range(0, 19);
        if (sel == 0)
            d.length = '0;
        else if (sel == 1 && max_len != 32'hFFFF_FFFF)
            d.length = $urandom_range(32'hFFFF_FFFF, max_len + 1);
        else if (sel < 6)
            d.length = $urandom_range(max_len < 64 ? max_len : 64, 1);
        else
            d.length = $urandom_range(max_len, 1);
        return d;
    endfunction

    function automatic ring_cmd_t op_word(input logic [1:0] op, input logic [3:0] rel);
        ring_cmd_t w;
        w     = '0;
        w.op  = op;
        w.rel = rel;
        if (op == OP_PUSH)
            w.d = random_desc(1'b0);
        return w;
    endfunction

    // mostly a held slot, sometimes any slot
    function automatic logic [3:0] pick_release();
        logic [3:0] s;
        s = 4'($urandom_range(0, DEPTH - 1));
        if ($urandom_range(0, 4) != 0)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (!held[s])
                    s = s + 1'b1;
            end
        end
        return s;
    endfunction

    // field extremes, push, pop and release, length checks, limit extremes
    task automatic test_basic_ops();
        ring_cmd_t w;
        send_word(op_word(OP_POP, 4'd0));
        w = '0;
        w.op = OP_PUSH;
        send_word(w);
        w.d = '1;
        send_word(w);
        w.d = '0;
        w.d.length = 32'd1;
        send_word(w);
        send_word(op_word(OP_POP, 4'd0));
        send_word(op_word(OP_POP, 4'd0));
        send_word(op_word(OP_POP, 4'd0));
        send_word(op_word(OP_RELEASE, 4'd0));
        send_word(op_word(OP_RELEASE, 4'd1));
        send_word(op_word(OP_RELEASE, 4'd15));
        // tightest limit
        write_max_len(32'd1);
        w.d = random_desc(1'b1);
        w.d.length = 32'd2;
        send_word(w);
        w.d.length = 32'hFFFF_FFFF;
        send_word(w);
        w.d.length = 32'd1;
        send_word(w);
        send_word(op_word(OP_POP, 4'd0));
        send_word(op_word(OP_RELEASE, 4'd2));
        write_max_len(32'hFFFF_FFFF);
    endtask

    // fill past full to drop the oldest, then run the head into held slots
    task automatic test_overflow();
        ring_cmd_t w;
        gaps_on = 1'b0;
        w = '0;
        w.op = OP_PUSH;
        repeat (DEPTH + 5)
        begin
            w.d = random_desc(1'b1);
            send_word(w);
        end
        repeat (3) send_word(op_word(OP_POP, 4'd0));
        repeat (8)
        begin
            w.d = random_desc(1'b1);
            send_word(w);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (held[i])
                send_word(op_word(OP_RELEASE, i[3:0]));
        end
        repeat (4)
        begin
            w.d = random_desc(1'b1);
            send_word(w);
        end
        gaps_on = 1'b1;
    endtask

    // random mix over several limits
    task automatic test_random_mix();
        logic [31:0] limits [5];
        int push_pct;
        int pop_pct;
        int roll;
        limits[0] = 32'hFFFF_FFFF;
        limits[1] = $urandom_range(4096, 2);
        limits[2] = 32'd1;
        limits[3] = 32'h8000_0000;
        limits[4] = $urandom_range(32'hFFFF_FFFF, 1);
        for (int p = 0; p < 5; p++)
        begin
            write_max_len(limits[p]);
            gaps_on  = (p != 3);
            push_pct = $urandom_range(40, 65);
            pop_pct  = $urandom_range(20, 35);
            repeat (100)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    send_word(op_word(OP_PUSH, 4'd0));
                else if (roll < push_pct + pop_pct)
                    send_word(op_word(OP_POP, 4'd0));
                else
                    send_word(op_word(OP_RELEASE, pick_release()));
            end
        end
        write_max_len(32'hFFFF_FFFF);
    endtask

    // shutdown blocks push and pop; length check still wins
    task automatic test_shutdown();
        ring_cmd_t w;
        send_word(op_word(OP_SHUTDOWN, 4'd0));
        w = '0;
        w.op = OP_PUSH;
        send_word(w);
        w.d = random_desc(1'b1);
        send_word(w);
        send_word(op_word(OP_POP, 4'd0));
        send_word(op_word(OP_RELEASE, pick_release()));
        send_word(op_word(OP_SHUTDOWN, 4'd0));
        repeat (40)
        begin
            w = op_word(2'($urandom_range(0, 3)), 4'($urandom_range(0, DEPTH - 1)));
            send_word(w);
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = OP_PUSH;
        cmd_bus.frame_seq    = '0;
        cmd_bus.frame_time   = '0;
        cmd_bus.pix_format   = '0;
        cmd_bus.frame_width  = '0;
        cmd_bus.frame_height = '0;
        cmd_bus.frame_length = '0;
        cmd_bus.release_slot = '0;
        foreach (stash[i])
            stash[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_overflow();
        test_random_mix();
        test_shutdown();

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
